FILE: hdl/torus_point_classify_project_macros.svh
// Assertion macros shared by the torus point classifier RTL.
`ifndef TORUS_POINT_CLASSIFY_PROJECT_MACROS_SVH
`define TORUS_POINT_CLASSIFY_PROJECT_MACROS_SVH

// same-cycle implication, off while reset is low
`define TPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define TPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tpc_pkg.sv
// Package: payload types, register indexes and status codes of the torus point classifier.
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int RADIUS_W  = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINOR_RADIUS = 2'd1;

    localparam logic [RADIUS_W-1:0] MAJOR_RADIUS_RST = 31'h7FFF_FFFF;
    localparam logic [RADIUS_W-1:0] MINOR_RADIUS_RST = 31'd131072;

    localparam logic [1:0] DEGEN_NONE     = 2'd0;
    localparam logic [1:0] DEGEN_Z_AXIS   = 2'd1;
    localparam logic [1:0] DEGEN_BACKBONE = 2'd2;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in;

    typedef struct packed {
        logic               is_inside;
        logic signed [31:0] surf_x;
        logic signed [31:0] surf_y;
        logic signed [31:0] surf_z;
        logic        [1:0]  degenerate;
    } t_out;

endpackage

`default_nettype wire

FILE: hdl/tpc_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module tpc_isqrt #(
    parameter int IN_W = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [IN_W-1:0]   i_radicand,
    output logic      [IN_W/2-1:0] o_root
);

    localparam int RootW = IN_W / 2;

    logic [IN_W-1:0]  r_rem  [RootW];
    logic [RootW-1:0] r_root [RootW];
    logic [IN_W-1:0]  n_rem  [RootW];
    logic [RootW-1:0] n_root [RootW];
    logic [IN_W-1:0]  rem_in [RootW];
    logic [IN_W-1:0]  trial  [RootW];
    logic [RootW-1:0] root_in[RootW];

    always_comb begin
        for (int k = 0; k < RootW; k++) begin
            if (k == 0) begin
                rem_in[k]  = i_radicand;
                root_in[k] = '0;
            end else begin
                rem_in[k]  = r_rem[k-1];
                root_in[k] = r_root[k-1];
            end
            trial[k] = (IN_W'(root_in[k]) << (RootW - k)) | (IN_W'(1) << (2 * (RootW - 1 - k)));
            if (rem_in[k] >= trial[k]) begin
                n_rem[k]  = rem_in[k] - trial[k];
                n_root[k] = root_in[k] | (RootW'(1) << (RootW - 1 - k));
            end else begin
                n_rem[k]  = rem_in[k];
                n_root[k] = root_in[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RootW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[RootW-1];

endmodule

`default_nettype wire

FILE: hdl/tpc_rdiv.sv
// Pipelined unsigned divider, one quotient bit per stage, rounded to nearest.
`timescale 1ns / 1ps
`default_nettype none

module tpc_rdiv #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32,
    parameter int QUO_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [QUO_W-1:0] o_quo
);

    localparam int CmpW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [CmpW-1:0]  r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [CmpW-1:0]  n_rem [QUO_W];
    logic [QUO_W-1:0] n_quo [QUO_W];
    logic [CmpW-1:0]  rem_in[QUO_W];
    logic [DEN_W-1:0] den_in[QUO_W];
    logic [QUO_W-1:0] quo_in[QUO_W];
    logic [CmpW-1:0]  shifted[QUO_W];
    logic [QUO_W-1:0] r_quo_rnd;
    logic             round_up;

    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            if (k == 0) begin
                rem_in[k] = CmpW'(i_num);
                den_in[k] = i_den;
                quo_in[k] = '0;
            end else begin
                rem_in[k] = r_rem[k-1];
                den_in[k] = r_den[k-1];
                quo_in[k] = r_quo[k-1];
            end
            shifted[k] = CmpW'(den_in[k]) << (QUO_W - 1 - k);
            if (rem_in[k] >= shifted[k]) begin
                n_rem[k] = rem_in[k] - shifted[k];
                n_quo[k] = quo_in[k] | (QUO_W'(1) << (QUO_W - 1 - k));
            end else begin
                n_rem[k] = rem_in[k];
                n_quo[k] = quo_in[k];
            end
        end
    end

    assign round_up = {r_rem[QUO_W-1][DEN_W-1:0], 1'b0} >= {1'b0, r_den[QUO_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= den_in[k];
                r_quo[k] <= n_quo[k];
            end
            r_quo_rnd <= r_quo[QUO_W-1] + QUO_W'(round_up);
        end
    end

    assign o_quo = r_quo_rnd;

endmodule

`default_nettype wire

FILE: hdl/torus_point_classify_project.sv
// Top level: pipelined torus point classifier and surface projector.
//
//  channel | direction | handshake              | beat
//  point   | in        | i_valid / o_stall      | i_data (t_in)
//  result  | out       | o_valid / i_stall      | o_data (t_out)
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One point is taken per cycle while o_stall is low.
//  Latency is set by two 32-stage square roots and two pairs of 32- and 33-stage dividers.
//  i_rst_n is synchronous, active low; it clears all valid bits and loads the radii.
//  A stalled result waits in the output register; one more beat parks in a
//  skid register, and only then is o_stall raised and the pipeline held.
`timescale 1ns / 1ps
`default_nettype none
`include "torus_point_classify_project_macros.svh"

module torus_point_classify_project (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire tpc_pkg::t_in                    i_data,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output tpc_pkg::t_out                        o_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tpc_pkg::RADIUS_W-1:0]    i_cfg_data
);

    import tpc_pkg::*;

    localparam int RootW   = 32;
    localparam int Div1Lat = RADIUS_W + 1;
    localparam int Div2Lat = RootW + 1;

    typedef struct packed {
        logic        vld;
        logic        xn;
        logic        yn;
        logic        zn;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [63:0] az2;
    } t_s1;

    typedef struct packed {
        logic        vld;
        logic        xn;
        logic        yn;
        logic        zn;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [63:0] az2;
        logic [31:0] rho;
        logic        dr_neg;
        logic [31:0] adr;
    } t_sc;

    typedef struct packed {
        logic        vld;
        logic        xn;
        logic        yn;
        logic        zn;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] rho;
        logic        dr_neg;
        logic [63:0] az2;
        logic [63:0] adr2;
        logic [62:0] n1;
        logic [62:0] n2;
        logic [61:0] r2;
    } t_sd;

    typedef struct packed {
        logic        vld;
        logic        xn;
        logic        yn;
        logic        zn;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] rho;
        logic        dr_neg;
        logic        in_tube;
        logic        rho_zero;
        logic        d2_zero;
        logic [62:0] n1;
        logic [62:0] n2;
    } t_s2;

    typedef struct packed {
        logic        vld;
        logic        xn;
        logic        yn;
        logic        zn;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] rho;
        logic        dr_neg;
        logic        in_tube;
        logic        rho_zero;
        logic        d2_zero;
    } t_s3;

    typedef struct packed {
        logic                vld;
        logic                xn;
        logic                yn;
        logic                zn;
        logic [31:0]         ax;
        logic [31:0]         ay;
        logic [31:0]         rho;
        logic                in_tube;
        logic                rho_zero;
        logic                d2_zero;
        logic                rad_neg;
        logic [31:0]         arad;
        logic [RADIUS_W-1:0] zq;
    } t_sf;

    typedef struct packed {
        logic                vld;
        logic                xn;
        logic                yn;
        logic                zn;
        logic                in_tube;
        logic                rho_zero;
        logic                d2_zero;
        logic                rad_neg;
        logic [RADIUS_W-1:0] zq;
    } t_s4;

    function automatic logic [31:0] f_sign_sat(input logic [31:0] mag, input logic neg);
        logic [31:0] res;
        if (!neg) begin
            res = mag[31] ? 32'h7FFF_FFFF : mag;
        end else begin
            res = (mag > 32'h8000_0000) ? 32'h8000_0000 : (~mag + 32'd1);
        end
        return res;
    endfunction

    logic [RADIUS_W-1:0] r_major;
    logic [RADIUS_W-1:0] r_minor;

    logic en;

    t_s1         r_a;
    t_s1         n_a;
    logic [63:0] r_a_sqx;
    logic [63:0] r_a_sqy;
    t_s1         r_l1 [RootW];
    logic [31:0] rho;

    t_sc         r_c;
    t_sc         n_c;
    logic [32:0] dr;
    t_sd         r_d;
    t_sd         n_d;
    t_s2         r_e;
    t_s2         n_e;
    logic [63:0] r_e_d2;
    logic [63:0] d2;
    t_s2         r_l2 [RootW];
    logic [31:0] d_root;

    logic [RADIUS_W-1:0] q_rad;
    logic [RADIUS_W-1:0] q_z;
    t_s3         r_l3 [Div1Lat];
    t_s3         l2_out;

    t_sf         r_f;
    t_sf         n_f;
    logic [32:0] rad;
    t_s4         r_g;
    t_s4         n_g;
    logic [31:0] r_g_rho;
    logic [63:0] r_g_px;
    logic [63:0] r_g_py;
    t_s4         r_l4 [Div2Lat];
    logic [31:0] q_x;
    logic [31:0] q_y;

    t_out        r_h_data;
    t_out        n_h_data;
    logic        r_h_vld;

    t_out        r_out_data;
    logic        r_out_vld;
    t_out        r_skid_data;
    logic        r_skid_vld;
    logic        out_take;

    assign en          = !r_skid_vld;
    assign o_stall     = r_skid_vld;
    assign o_cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major <= MAJOR_RADIUS_RST;
            r_minor <= MINOR_RADIUS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAJOR_RADIUS: r_major <= i_cfg_data;
                CFG_MINOR_RADIUS: r_minor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // magnitudes and squares
    always_comb begin
        n_a.vld = i_valid;
        n_a.xn  = i_data.pos_x[31];
        n_a.yn  = i_data.pos_y[31];
        n_a.zn  = i_data.pos_z[31];
        n_a.ax  = i_data.pos_x[31] ? (~i_data.pos_x + 32'd1) : i_data.pos_x;
        n_a.ay  = i_data.pos_y[31] ? (~i_data.pos_y + 32'd1) : i_data.pos_y;
        n_a.az  = i_data.pos_z[31] ? (~i_data.pos_z + 32'd1) : i_data.pos_z;
        n_a.az2 = {32'd0, n_a.az} * {32'd0, n_a.az};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sqx <= {32'd0, n_a.ax} * {32'd0, n_a.ax};
            r_a_sqy <= {32'd0, n_a.ay} * {32'd0, n_a.ay};
        end
    end

    tpc_isqrt #(.IN_W(64)) u_rho_sqrt (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_radicand(r_a_sqx + r_a_sqy),
        .o_root    (rho)
    );

    // offset from the backbone
    always_comb begin
        dr         = {1'b0, rho} - {2'b00, r_major};
        n_c.vld    = r_l1[RootW-1].vld;
        n_c.xn     = r_l1[RootW-1].xn;
        n_c.yn     = r_l1[RootW-1].yn;
        n_c.zn     = r_l1[RootW-1].zn;
        n_c.ax     = r_l1[RootW-1].ax;
        n_c.ay     = r_l1[RootW-1].ay;
        n_c.az     = r_l1[RootW-1].az;
        n_c.az2    = r_l1[RootW-1].az2;
        n_c.rho    = rho;
        n_c.dr_neg = dr[32];
        n_c.adr    = dr[32] ? (~dr[31:0] + 32'd1) : dr[31:0];
    end

    always_comb begin
        n_d.vld    = r_c.vld;
        n_d.xn     = r_c.xn;
        n_d.yn     = r_c.yn;
        n_d.zn     = r_c.zn;
        n_d.ax     = r_c.ax;
        n_d.ay     = r_c.ay;
        n_d.rho    = r_c.rho;
        n_d.dr_neg = r_c.dr_neg;
        n_d.az2    = r_c.az2;
        n_d.adr2   = {32'd0, r_c.adr} * {32'd0, r_c.adr};
        n_d.n1     = {32'd0, r_minor} * {31'd0, r_c.adr};
        n_d.n2     = {32'd0, r_minor} * {31'd0, r_c.az};
        n_d.r2     = {31'd0, r_minor} * {31'd0, r_minor};
    end

    always_comb begin
        d2           = r_d.adr2 + r_d.az2;
        n_e.vld      = r_d.vld;
        n_e.xn       = r_d.xn;
        n_e.yn       = r_d.yn;
        n_e.zn       = r_d.zn;
        n_e.ax       = r_d.ax;
        n_e.ay       = r_d.ay;
        n_e.rho      = r_d.rho;
        n_e.dr_neg   = r_d.dr_neg;
        n_e.in_tube  = d2 <= {2'b00, r_d.r2};
        n_e.rho_zero = r_d.rho == 32'd0;
        n_e.d2_zero  = d2 == 64'd0;
        n_e.n1       = r_d.n1;
        n_e.n2       = r_d.n2;
    end

    tpc_isqrt #(.IN_W(64)) u_dist_sqrt (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_radicand(r_e_d2),
        .o_root    (d_root)
    );

    tpc_rdiv #(.NUM_W(63), .DEN_W(32), .QUO_W(RADIUS_W)) u_rad_div (
        .i_clk(i_clk),
        .i_en (en),
        .i_num(r_l2[RootW-1].n1),
        .i_den(d_root),
        .o_quo(q_rad)
    );

    tpc_rdiv #(.NUM_W(63), .DEN_W(32), .QUO_W(RADIUS_W)) u_z_div (
        .i_clk(i_clk),
        .i_en (en),
        .i_num(r_l2[RootW-1].n2),
        .i_den(d_root),
        .o_quo(q_z)
    );

    always_comb begin
        l2_out.vld      = r_l2[RootW-1].vld;
        l2_out.xn       = r_l2[RootW-1].xn;
        l2_out.yn       = r_l2[RootW-1].yn;
        l2_out.zn       = r_l2[RootW-1].zn;
        l2_out.ax       = r_l2[RootW-1].ax;
        l2_out.ay       = r_l2[RootW-1].ay;
        l2_out.rho      = r_l2[RootW-1].rho;
        l2_out.dr_neg   = r_l2[RootW-1].dr_neg;
        l2_out.in_tube  = r_l2[RootW-1].in_tube;
        l2_out.rho_zero = r_l2[RootW-1].rho_zero;
        l2_out.d2_zero  = r_l2[RootW-1].d2_zero;
    end

    // radius of the surface point in the XY plane
    always_comb begin
        rad = r_l3[Div1Lat-1].dr_neg ? ({2'b00, r_major} - {2'b00, q_rad})
                                     : ({2'b00, r_major} + {2'b00, q_rad});
        n_f.vld      = r_l3[Div1Lat-1].vld;
        n_f.xn       = r_l3[Div1Lat-1].xn;
        n_f.yn       = r_l3[Div1Lat-1].yn;
        n_f.zn       = r_l3[Div1Lat-1].zn;
        n_f.ax       = r_l3[Div1Lat-1].ax;
        n_f.ay       = r_l3[Div1Lat-1].ay;
        n_f.rho      = r_l3[Div1Lat-1].rho;
        n_f.in_tube  = r_l3[Div1Lat-1].in_tube;
        n_f.rho_zero = r_l3[Div1Lat-1].rho_zero;
        n_f.d2_zero  = r_l3[Div1Lat-1].d2_zero;
        n_f.rad_neg  = rad[32];
        n_f.arad     = rad[32] ? (~rad[31:0] + 32'd1) : rad[31:0];
        n_f.zq       = q_z;
    end

    always_comb begin
        n_g.vld      = r_f.vld;
        n_g.xn       = r_f.xn;
        n_g.yn       = r_f.yn;
        n_g.zn       = r_f.zn;
        n_g.in_tube  = r_f.in_tube;
        n_g.rho_zero = r_f.rho_zero;
        n_g.d2_zero  = r_f.d2_zero;
        n_g.rad_neg  = r_f.rad_neg;
        n_g.zq       = r_f.zq;
    end

    tpc_rdiv #(.NUM_W(64), .DEN_W(32), .QUO_W(32)) u_x_div (
        .i_clk(i_clk),
        .i_en (en),
        .i_num(r_g_px),
        .i_den(r_g_rho),
        .o_quo(q_x)
    );

    tpc_rdiv #(.NUM_W(64), .DEN_W(32), .QUO_W(32)) u_y_div (
        .i_clk(i_clk),
        .i_en (en),
        .i_num(r_g_py),
        .i_den(r_g_rho),
        .o_quo(q_y)
    );

    // sign, saturate and flag
    always_comb begin
        n_h_data.is_inside = r_l4[Div2Lat-1].in_tube;
        if (r_l4[Div2Lat-1].rho_zero) begin
            n_h_data.degenerate = DEGEN_Z_AXIS;
            n_h_data.surf_x     = '0;
            n_h_data.surf_y     = '0;
            n_h_data.surf_z     = '0;
        end else if (r_l4[Div2Lat-1].d2_zero) begin
            n_h_data.degenerate = DEGEN_BACKBONE;
            n_h_data.surf_x     = '0;
            n_h_data.surf_y     = '0;
            n_h_data.surf_z     = '0;
        end else begin
            n_h_data.degenerate = DEGEN_NONE;
            n_h_data.surf_x     = f_sign_sat(q_x, r_l4[Div2Lat-1].xn ^ r_l4[Div2Lat-1].rad_neg);
            n_h_data.surf_y     = f_sign_sat(q_y, r_l4[Div2Lat-1].yn ^ r_l4[Div2Lat-1].rad_neg);
            n_h_data.surf_z     = f_sign_sat({1'b0, r_l4[Div2Lat-1].zq}, r_l4[Div2Lat-1].zn);
        end
    end

    // pipeline registers; valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
            r_c.vld <= 1'b0;
            r_d.vld <= 1'b0;
            r_e.vld <= 1'b0;
            r_f.vld <= 1'b0;
            r_g.vld <= 1'b0;
            r_h_vld <= 1'b0;
            for (int k = 0; k < RootW; k++) begin
                r_l1[k].vld <= 1'b0;
                r_l2[k].vld <= 1'b0;
            end
            for (int k = 0; k < Div1Lat; k++) begin
                r_l3[k].vld <= 1'b0;
            end
            for (int k = 0; k < Div2Lat; k++) begin
                r_l4[k].vld <= 1'b0;
            end
        end else if (en) begin
            r_a     <= n_a;
            r_l1[0] <= r_a;
            for (int k = 1; k < RootW; k++) begin
                r_l1[k] <= r_l1[k-1];
            end
            r_c     <= n_c;
            r_d     <= n_d;
            r_e     <= n_e;
            r_e_d2  <= d2;
            r_l2[0] <= r_e;
            for (int k = 1; k < RootW; k++) begin
                r_l2[k] <= r_l2[k-1];
            end
            r_l3[0] <= l2_out;
            for (int k = 1; k < Div1Lat; k++) begin
                r_l3[k] <= r_l3[k-1];
            end
            r_f     <= n_f;
            r_g     <= n_g;
            r_g_rho <= r_f.rho;
            r_g_px  <= {32'd0, r_f.ax} * {32'd0, r_f.arad};
            r_g_py  <= {32'd0, r_f.ay} * {32'd0, r_f.arad};
            r_l4[0] <= r_g;
            for (int k = 1; k < Div2Lat; k++) begin
                r_l4[k] <= r_l4[k-1];
            end
            r_h_data <= n_h_data;
            r_h_vld  <= r_l4[Div2Lat-1].vld;
        end
    end

    // output register and skid
    assign out_take = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
                r_skid_vld <= 1'b0;
            end
        end else if (r_h_vld) begin
            if (!r_out_vld || out_take) begin
                r_out_data <= r_h_data;
                r_out_vld  <= 1'b1;
            end else begin
                r_skid_data <= r_h_data;
                r_skid_vld  <= 1'b1;
            end
        end else if (out_take) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out_data;

    `TPC_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid holds a beat while the output register is empty")
    `TPC_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_vld && !i_stall, r_out_vld && !r_skid_vld, "skid beat not moved to output")
    `TPC_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, o_valid && (o_data.degenerate != DEGEN_NONE), (o_data.surf_x == 32'sd0) && (o_data.surf_y == 32'sd0) && (o_data.surf_z == 32'sd0), "degenerate point with nonzero surface point")
    `TPC_ASSERT_IMPL(a_backbone_inside, i_clk, i_rst_n, o_valid && (o_data.degenerate == DEGEN_BACKBONE), o_data.is_inside, "point on backbone reported outside")

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Testbench: random and directed points against a torus projection predictor.
`timescale 1ns / 1ps

class torus_scoreboard;
    longint unsigned major_r;
    longint unsigned minor_r;
    tpc_pkg::t_out   awaited[$];
    int              errors;

    function new();
        major_r = tpc_pkg::MAJOR_RADIUS_RST;
        minor_r = tpc_pkg::MINOR_RADIUS_RST;
        errors  = 0;
    endfunction

    function void set_reg(logic [tpc_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
        if (idx == tpc_pkg::CFG_MAJOR_RADIUS) major_r = val;
        else if (idx == tpc_pkg::CFG_MINOR_RADIUS) minor_r = val;
    endfunction

    function longint unsigned root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function longint round_div(longint unsigned mag, bit neg, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = mag / den;
        rem = mag % den;
        if (rem >= den - rem) q++;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function longint unsigned absval(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function void note_point(tpc_pkg::t_in p);
        longint x, y, z, dr, rad, xs, ys, zs;
        longint unsigned ax, ay, az, rho, adr, d2, r2, d, arad;
        tpc_pkg::t_out e;
        x    = longint'(p.pos_x);
        y    = longint'(p.pos_y);
        z    = longint'(p.pos_z);
        ax   = absval(x);
        ay   = absval(y);
        az   = absval(z);
        rho  = root(ax * ax + ay * ay);
        dr   = longint'(rho) - longint'(major_r);
        adr  = absval(dr);
        d2   = adr * adr + az * az;
        r2   = minor_r * minor_r;
        e    = '0;
        e.is_inside = (d2 <= r2);
        if (rho == 0) begin
            e.degenerate = tpc_pkg::DEGEN_Z_AXIS;
        end else if (d2 == 0) begin
            e.degenerate = tpc_pkg::DEGEN_BACKBONE;
        end else begin
            e.degenerate = tpc_pkg::DEGEN_NONE;
            d    = root(d2);
            rad  = longint'(major_r) + round_div(minor_r * adr, dr < 0, d);
            zs   = round_div(minor_r * az, z < 0, d);
            arad = absval(rad);
            xs   = round_div(ax * arad, (x < 0) != (rad < 0), rho);
            ys   = round_div(ay * arad, (y < 0) != (rad < 0), rho);
            e.surf_x = clip32(xs);
            e.surf_y = clip32(ys);
            e.surf_z = clip32(zs);
        end
        awaited.push_back(e);
    endfunction

    function void check_result(tpc_pkg::t_out got);
        tpc_pkg::t_out e;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        e = awaited.pop_front();
        if (got.is_inside !== e.is_inside) begin
            $display("%0t: is_inside expected %0d actual %0d", $time, e.is_inside, got.is_inside);
            errors++;
        end
        if (got.surf_x !== e.surf_x) begin
            $display("%0t: surf_x expected %h actual %h", $time, e.surf_x, got.surf_x);
            errors++;
        end
        if (got.surf_y !== e.surf_y) begin
            $display("%0t: surf_y expected %h actual %h", $time, e.surf_y, got.surf_y);
            errors++;
        end
        if (got.surf_z !== e.surf_z) begin
            $display("%0t: surf_z expected %h actual %h", $time, e.surf_z, got.surf_z);
            errors++;
        end
        if (got.degenerate !== e.degenerate) begin
            $display("%0t: degenerate expected %0d actual %0d", $time, e.degenerate,
                     got.degenerate);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    tpc_pkg::t_in  i_data;
    logic o_valid;
    logic i_stall;
    tpc_pkg::t_out o_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [tpc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [tpc_pkg::RADIUS_W-1:0]  i_cfg_data;

    torus_scoreboard sb;
    bit quiet;
    bit squeeze;
    bit done_rx;

    torus_point_classify_project i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        tpc_pkg::t_in p;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        i_valid <= 1'b1;
        i_data  <= p;
        do @(posedge i_clk); while (o_stall);
        sb.note_point(p);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [tpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [30:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic logic [31:0] offset(longint unsigned span);
        longint unsigned m;
        m = (span > 64'd16777216) ? 64'd16777216 : span;
        return 32'(longint'({$urandom, $urandom} % (2 * m + 1)) - longint'(m));
    endfunction

    task automatic random_points(input int n);
        longint unsigned m;
        logic [31:0] a, b;
        m = sb.major_r;
        squeeze = !quiet;
        for (int k = 0; k < n; k++) begin
            a = 32'(m * 3 / 5);
            b = 32'(m * 4 / 5);
            case ($urandom_range(0, 9))
                0: send_point($urandom, $urandom, $urandom);
                1: send_point(32'd0, 32'd0, $urandom);
                2: send_point($urandom_range(0, 1) ? a : -a, $urandom_range(0, 1) ? b : -b,
                              32'd0);
                3: send_point(32'($urandom) >>> $urandom_range(0, 31),
                              32'($urandom) >>> $urandom_range(0, 31),
                              32'($urandom) >>> $urandom_range(0, 31));
                4: send_point(32'(m) + offset(sb.minor_r * 2), offset(16),
                              offset(sb.minor_r * 2));
                default: send_point(a + offset(sb.minor_r * 2), b + offset(sb.minor_r * 2),
                                    offset(sb.minor_r * 2));
            endcase
        end
    endtask

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) sb.check_result(o_data);
            if (hold > 0) hold--;
            else if (squeeze) begin
                hold    = 300;
                squeeze = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 9);
            else if (!quiet && $urandom_range(0, 3) == 0) hold = 0;
            i_stall <= (hold > 0);
        end
    end

    initial begin
        sb          = new();
        quiet       = 1'b0;
        squeeze     = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_data      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = tpc_pkg::CFG_MAJOR_RADIUS;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'd0, 32'd0, 32'h7FFF_FFFF);
        send_point(32'd0, 32'd0, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'd0, 32'd0);
        send_point(32'h8000_0001, 32'd0, 32'd0);
        send_point(32'd0, 32'h7FFF_FFFF, 32'd0);
        send_point(32'h7FFF_FFFF, 32'd0, 32'd1);
        send_point(32'h7FFF_FFFF, 32'd0, 32'h0002_0000);
        send_point(32'h8000_0000, 32'd0, 32'd0);
        send_point(32'd0, 32'h8000_0000, 32'd0);
        send_point(32'd1, 32'd0, 32'd0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        random_points(190);
        drain();

        write_reg(tpc_pkg::CFG_MAJOR_RADIUS, 31'h7FFF_FFFF);
        write_reg(tpc_pkg::CFG_MINOR_RADIUS, 31'd0);
        send_point(32'h7FFF_FFFF, 32'd0, 32'd0);
        random_points(150);
        drain();

        write_reg(tpc_pkg::CFG_MAJOR_RADIUS, 31'd1);
        write_reg(tpc_pkg::CFG_MINOR_RADIUS, 31'h7FFF_FFFF);
        send_point(32'd1, 32'd0, 32'd0);
        random_points(150);
        drain();

        write_reg(tpc_pkg::CFG_MAJOR_RADIUS, 31'h000A_0000);
        write_reg(tpc_pkg::CFG_MINOR_RADIUS, 31'h0003_0000);
        write_reg(2'd2, 31'h1234_5678);
        write_reg(2'd3, 31'h7FFF_FFFF);
        random_points(200);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            logic [30:0] maj;
            maj = 31'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 28));
            if (maj == 0) maj = 1;
            write_reg(tpc_pkg::CFG_MAJOR_RADIUS, maj);
            write_reg(tpc_pkg::CFG_MINOR_RADIUS, 31'($urandom_range(0, maj)));
            if (ph == 2) quiet = 1'b1;
            random_points(130);
            drain();
        end

        if (sb.errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end
endmodule
